>>> hdl/utcfat_pkg.sv
// package for the utc to local fat timestamp unit: transaction structs,
// calendar constants, register indexes and the month length function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package utcfat_pkg;

    // calendar limits
    localparam int unsigned YEAR_MIN      = 1980;
    localparam int unsigned YEAR_MAX      = 2107;
    localparam int unsigned YEAR_NO_LEAP  = 2100;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned MAX_HOUR      = 23;
    localparam int unsigned MAX_MIN_SEC   = 59;
    localparam int unsigned MONTHS        = 12;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UTC_OFFSET    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_YEAR = 1'b1;

    // reset values of the registers
    localparam logic [4:0]  RST_UTC_OFFSET    = 5'd10;
    localparam logic [11:0] RST_FALLBACK_YEAR = 12'd1980;

    // one input transaction
    typedef struct packed {
        logic        reading_present;
        logic        date_valid;
        logic        time_valid;
        logic [13:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic [5:0]  utc_second;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic [31:0] fat_stamp;
        logic        from_reading;
    } t_out_item;

    // days in a month, zero for a month code that means nothing
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
            4'd2:                                        days = leap ? 5'd29 : 5'd28;
            default:                                     days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

>>> hdl/utc_to_local_fat_timestamp_unit.sv
// top level of the utc to local fat timestamp unit: checks a utc reading,
// shifts it to local time and packs a 32-bit fat timestamp
// depends on utcfat_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage: a transaction is taken at every rising edge with start high; busy
// is always low, so a new reading may be issued in every cycle. Each reading
// gives exactly one result: it is held in the input register, then passes
// through the date check, hour offset, calendar rollover and packing
// logic into the result register. The result sits on o_result for a single
// cycle with o_strobe high; the receiver cannot stall and must take it then.
// An unusable reading, or a rollover past 2107, yields January 1 of the
// fallback year at 00:00:00 with from_reading low. Configuration writes take
// effect at once and should be made only while no transaction is in flight.
module utc_to_local_fat_timestamp_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  utcfat_pkg::t_in_item           i_item,
    input  wire                                  i_cfg_we,
    input  wire  [utcfat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [utcfat_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                 o_strobe,
    output utcfat_pkg::t_out_item                o_result
);
    import utcfat_pkg::*;

    localparam logic [13:0] Y_MIN14   = 14'(YEAR_MIN);
    localparam logic [13:0] Y_MAX14   = 14'(YEAR_MAX);
    localparam logic [13:0] Y_NOLEAP  = 14'(YEAR_NO_LEAP);
    localparam logic [11:0] Y_MIN12   = 12'(YEAR_MIN);
    localparam logic [11:0] Y_MAX12   = 12'(YEAR_MAX);
    localparam logic [5:0]  H_DAY     = 6'(HOURS_PER_DAY);
    localparam logic [4:0]  H_MAX     = 5'(MAX_HOUR);
    localparam logic [5:0]  MS_MAX    = 6'(MAX_MIN_SEC);
    localparam logic [3:0]  M_LAST    = 4'(MONTHS);

    // configuration registers
    logic [4:0]  r_utc_offset;
    logic [11:0] r_fallback_year;

    // input stage
    logic        r_in_valid;
    t_in_item    r_in;

    // result stage
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    // combinational check and pack
    logic [13:0] y;
    logic [3:0]  mo;
    logic [4:0]  d, h, off;
    logic [5:0]  mi, s;
    logic        leap, in_ok, ok;
    logic [4:0]  mdays;
    logic [5:0]  hsum;
    logic        day_roll, month_roll, year_roll;
    logic [4:0]  lh, ld;
    logic [3:0]  lm;
    logic [13:0] yoff;
    logic [6:0]  ly;
    logic [11:0] fy, fyoff;

    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utc_offset    <= RST_UTC_OFFSET;
            r_fallback_year <= RST_FALLBACK_YEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UTC_OFFSET:    r_utc_offset    <= i_cfg_wdata[4:0];
                CFG_FALLBACK_YEAR: r_fallback_year <= i_cfg_wdata;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        if (start) begin
            r_in <= i_item;
        end
    end

    // reading check, local time shift and packing
    always_comb begin
        y  = r_in.utc_year;
        mo = r_in.utc_month;
        d  = r_in.utc_day;
        h  = r_in.utc_hour;
        mi = r_in.utc_minute;
        s  = r_in.utc_second;
        off = (r_utc_offset > H_MAX) ? H_MAX : r_utc_offset;

        // leap rule within 1980..2107: 2000 is leap, 2100 is not
        leap  = (y[1:0] == 2'b00) && (y != Y_NOLEAP);
        mdays = days_in_month(mo, leap);
        in_ok = r_in.reading_present && r_in.date_valid && r_in.time_valid &&
                (y >= Y_MIN14) && (y <= Y_MAX14) && (mdays != 5'd0) &&
                (d != 5'd0) && (d <= mdays) && (h <= H_MAX) &&
                (mi <= MS_MAX) && (s <= MS_MAX);

        // hour offset and calendar rollover
        hsum       = {1'b0, h} + {1'b0, off};
        day_roll   = (hsum >= H_DAY);
        lh         = day_roll ? 5'(hsum - H_DAY) : hsum[4:0];
        month_roll = day_roll && (d == mdays);
        year_roll  = month_roll && (mo == M_LAST);
        ld = month_roll ? 5'd1 : (day_roll ? 5'(d + 5'd1) : d);
        lm = year_roll ? 4'd1 : (month_roll ? 4'(mo + 4'd1) : mo);
        yoff = 14'(y - Y_MIN14);
        ly   = 7'(yoff[6:0] + {6'd0, year_roll});
        ok   = in_ok && !(year_roll && (y == Y_MAX14));

        // fallback year clamped to the fat range
        fy = (r_fallback_year < Y_MIN12) ? Y_MIN12 :
             (r_fallback_year > Y_MAX12) ? Y_MAX12 : r_fallback_year;
        fyoff = 12'(fy - Y_MIN12);

        if (ok) begin
            n_out.fat_stamp    = {ly, lm, ld, lh, mi, s[5:1]};
            n_out.from_reading = 1'b1;
        end else begin
            n_out.fat_stamp    = {fyoff[6:0], 4'd1, 5'd1, 5'd0, 6'd0, 5'd0};
            n_out.from_reading = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // every accepted transaction comes out after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_strobe)
        else $error("accepted transaction produced no result");

    // fallback stamps are january 1 at midnight
    a_fallback_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.from_reading |->
            o_result.fat_stamp[24:0] == {4'd1, 5'd1, 16'd0})
        else $error("fallback stamp is not january 1 00:00:00");

    // stamps from a reading carry a real month, day and hour
    a_local_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.from_reading |->
            o_result.fat_stamp[24:21] != 4'd0 && o_result.fat_stamp[24:21] <= M_LAST &&
            o_result.fat_stamp[20:16] != 5'd0 && o_result.fat_stamp[15:11] <= H_MAX)
        else $error("local date or hour out of range");

    // two-second field of a reading stays below thirty
    a_seconds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.from_reading |-> o_result.fat_stamp[4:0] <= 5'd29)
        else $error("seconds field out of range");

endmodule

`default_nettype wire
